[hw/rtl/vpt_pkg.sv]
// Shared constants, types and the arctangent table of the vehicle pose tracker.
`timescale 1ns / 1ps
`default_nettype none
package vpt_pkg;
  localparam int CordicStepsDef = 24;
  localparam int FracBitsDef    = 16;
  localparam int Q30            = 30;

  localparam int OpaW  = 34;
  localparam int OpbW  = 33;
  localparam int ProdW = OpaW + OpbW;
  localparam int AccW  = 35;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_G2V  = 2'd2;
  localparam logic [1:0] OP_V2G  = 2'd3;

  localparam logic [1:0] REG_INV_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED     = 2'd1;

  localparam logic [31:0] InvWheelbaseRst = 32'd32768;
  localparam logic [30:0] MaxSpeedRst     = 31'd6553600;

  localparam logic signed [32:0] RadToBam   = 33'sd683565276;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } trig_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;
        5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;
        5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029;
        5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A;
        5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003;
        5'd29: r = 32'h00000001;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

[hw/rtl/vpt_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
`timescale 1ns / 1ps
`default_nettype none
module vpt_cordic #(
  parameter int CORDIC_STEPS = vpt_pkg::CordicStepsDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   angle,
  output vpt_pkg::trig_t     trig
);
  import vpt_pkg::*;

  localparam int CntW = 5;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               flip_r, flip_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic signed [33:0] xs, ys, xf, yf, xc, yc;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      flip_nxt = angle[31] ^ angle[30];
      cnt_nxt  = '0;
      x_nxt    = CordicGain;
      y_nxt    = '0;
      z_nxt    = signed'({angle[31] ^ flip_nxt, angle[30:0]});
    end else if (busy_r) begin
      if (!z_r[31]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - signed'(atan_bam(cnt_r));
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + signed'(atan_bam(cnt_r));
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    flip_r <= flip_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xc = (xf > OneQ30) ? OneQ30 : ((xf < -OneQ30) ? -OneQ30 : xf);
    yc = (yf > OneQ30) ? OneQ30 : ((yf < -OneQ30) ? -OneQ30 : yf);
    trig.done  = done_r;
    trig.cos_v = xc[31:0];
    trig.sin_v = yc[31:0];
  end
endmodule
`default_nettype wire

[hw/rtl/vehicle_pose_tracker.sv]
// Top level of the vehicle pose tracker: sequencer, shared multiplier and pose state.
// Each word takes one operation: load, bicycle-model move, or a frame transform of a
// point. A load goes straight to the finishing state. Move and transforms start the
// CORDIC and run their products through one registered multiplier, each product
// passing the multiply state and then the write-back state (seven products for a move,
// four for a transform); the move products that do not need the angle overlap the
// CORDIC. The input is not ready while a word is in work; a finished result waits in
// the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none
module vehicle_pose_tracker #(
  parameter int CORDIC_STEPS = vpt_pkg::CordicStepsDef,
  parameter int FRAC_BITS    = vpt_pkg::FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic [31:0]        in_heading,
  input  wire logic signed [31:0] in_speed,
  input  wire logic signed [31:0] in_steer,
  input  wire logic signed [31:0] in_accel,
  input  wire logic [20:0]        in_time_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic [31:0]             out_heading,
  output logic signed [31:0]      out_speed,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import vpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    begin
      if (v > ProdW'(64'sd2147483647)) r = 32'sh7FFFFFFF;
      else if (v < -ProdW'(64'sd2147483648)) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  step_r;
  logic [31:0] inv_wb_r;
  logic [30:0] max_speed_r;

  logic signed [31:0] pose_x_r, pose_y_r, pose_speed_r, pose_steer_r, pose_accel_r;
  logic [31:0]        pose_heading_r;

  logic [1:0]         op_r;
  logic signed [31:0] px_r, py_r, ld_speed_r, ld_steer_r, ld_accel_r;
  logic [31:0]        ld_heading_r;
  logic [20:0]        dt_r;

  logic signed [31:0]      dist_r, tmp_r, spd_r;
  logic [31:0]             dh_r;
  logic signed [AccW-1:0]  ax_r, ay_r;
  logic signed [ProdW-1:0] prod_r;
  logic                    q30_r;

  logic signed [OpaW-1:0]  opa;
  logic signed [OpbW-1:0]  opb;
  logic                    need_trig, use_q30, last_step;
  logic signed [ProdW-1:0] shifted, spd_sum;
  logic signed [31:0]      spd_sat;
  logic signed [32:0]      vx, vy;
  logic                    accept, out_free;
  trig_t                   trig;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign vx = 33'(px_r) - 33'(pose_x_r);
  assign vy = 33'(py_r) - 33'(pose_y_r);

  vpt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .angle (pose_heading_r),
    .trig  (trig)
  );

  always_comb begin
    opa       = '0;
    opb       = '0;
    need_trig = 1'b1;
    use_q30   = 1'b1;
    last_step = (step_r == 3'd3);
    unique case (op_r)
      OP_MOVE: begin
        last_step = (step_r == 3'd6);
        need_trig = (step_r >= 3'd5);
        use_q30   = (step_r >= 3'd5);
        case (step_r)
          3'd0: begin opa = OpaW'(pose_speed_r); opb = OpbW'({1'b0, dt_r}); end
          3'd1: begin opa = OpaW'(pose_steer_r); opb = OpbW'(dist_r); end
          3'd2: begin opa = OpaW'(tmp_r); opb = OpbW'({1'b0, inv_wb_r}); end
          3'd3: begin opa = OpaW'(tmp_r); opb = RadToBam; end
          3'd4: begin opa = OpaW'(pose_accel_r); opb = OpbW'({1'b0, dt_r}); end
          3'd5: begin opa = OpaW'(dist_r); opb = OpbW'(trig.cos_v); end
          default: begin opa = OpaW'(dist_r); opb = OpbW'(trig.sin_v); end
        endcase
      end
      OP_G2V: begin
        case (step_r)
          3'd0: begin opa = OpaW'(vx); opb = OpbW'(trig.cos_v); end
          3'd1: begin opa = OpaW'(vy); opb = OpbW'(trig.sin_v); end
          3'd2: begin opa = OpaW'(vy); opb = OpbW'(trig.cos_v); end
          default: begin opa = OpaW'(vx); opb = OpbW'(trig.sin_v); end
        endcase
      end
      OP_V2G: begin
        case (step_r)
          3'd0: begin opa = OpaW'(px_r); opb = OpbW'(trig.cos_v); end
          3'd1: begin opa = OpaW'(py_r); opb = OpbW'(trig.sin_v); end
          3'd2: begin opa = OpaW'(px_r); opb = OpbW'(trig.sin_v); end
          default: begin opa = OpaW'(py_r); opb = OpbW'(trig.cos_v); end
        endcase
      end
      default: begin
        need_trig = 1'b0;
      end
    endcase
  end

  always_comb begin
    shifted = q30_r ? (prod_r >>> Q30) : (prod_r >>> FRAC_BITS);
    spd_sum = shifted + ProdW'(pose_speed_r);
    spd_sat = sat32(spd_sum);
    if (spd_sat > signed'({1'b0, max_speed_r})) spd_sat = signed'({1'b0, max_speed_r});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = (in_opcode == OP_LOAD) ? ST_FIN : ST_MUL;
      ST_MUL:  if (!need_trig || trig.done) state_nxt = ST_WB;
      ST_WB:   state_nxt = last_step ? ST_FIN : ST_MUL;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid      <= 1'b0;
      inv_wb_r       <= InvWheelbaseRst;
      max_speed_r    <= MaxSpeedRst;
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
      pose_speed_r   <= '0;
      pose_steer_r   <= '0;
      pose_accel_r   <= '0;
      step_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INV_WHEELBASE: inv_wb_r <= cfg_data;
          REG_MAX_SPEED:     max_speed_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) step_r <= '0;
      if (state_r == ST_WB) step_r <= step_r + 1'b1;
      if (state_r == ST_FIN && out_free) begin
        out_valid <= 1'b1;
        unique case (op_r)
          OP_LOAD: begin
            pose_x_r       <= px_r;
            pose_y_r       <= py_r;
            pose_heading_r <= ld_heading_r;
            pose_speed_r   <= ld_speed_r;
            pose_steer_r   <= ld_steer_r;
            pose_accel_r   <= ld_accel_r;
          end
          OP_MOVE: begin
            pose_x_r       <= sat32(ProdW'(ax_r));
            pose_y_r       <= sat32(ProdW'(ay_r));
            pose_heading_r <= pose_heading_r + dh_r;
            pose_speed_r   <= spd_r;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_opcode;
      px_r         <= in_pos_x;
      py_r         <= in_pos_y;
      ld_heading_r <= in_heading;
      ld_speed_r   <= in_speed;
      ld_steer_r   <= in_steer;
      ld_accel_r   <= in_accel;
      dt_r         <= in_time_step;
      ax_r         <= (in_opcode == OP_G2V) ? '0 : AccW'(pose_x_r);
      ay_r         <= (in_opcode == OP_G2V) ? '0 : AccW'(pose_y_r);
    end
    if (state_r == ST_MUL) begin
      prod_r <= ProdW'(opa * opb);
      q30_r  <= use_q30;
    end
    if (state_r == ST_WB) begin
      unique case (op_r)
        OP_MOVE: begin
          case (step_r)
            3'd0: dist_r <= sat32(shifted);
            3'd1: tmp_r  <= sat32(shifted);
            3'd2: tmp_r  <= sat32(shifted);
            3'd3: dh_r   <= shifted[31:0];
            3'd4: spd_r  <= spd_sat;
            3'd5: ax_r   <= ax_r + shifted[AccW-1:0];
            default: ay_r <= ay_r + shifted[AccW-1:0];
          endcase
        end
        OP_G2V: begin
          case (step_r)
            3'd0, 3'd1: ax_r <= ax_r + shifted[AccW-1:0];
            3'd2:       ay_r <= ay_r + shifted[AccW-1:0];
            default:    ay_r <= ay_r - shifted[AccW-1:0];
          endcase
        end
        OP_V2G: begin
          case (step_r)
            3'd0:    ax_r <= ax_r + shifted[AccW-1:0];
            3'd1:    ax_r <= ax_r - shifted[AccW-1:0];
            default: ay_r <= ay_r + shifted[AccW-1:0];
          endcase
        end
        default: ;
      endcase
    end
    if (state_r == ST_FIN && out_free) begin
      unique case (op_r)
        OP_LOAD: begin
          out_x       <= px_r;
          out_y       <= py_r;
          out_heading <= ld_heading_r;
          out_speed   <= ld_speed_r;
        end
        OP_MOVE: begin
          out_x       <= sat32(ProdW'(ax_r));
          out_y       <= sat32(ProdW'(ay_r));
          out_heading <= pose_heading_r + dh_r;
          out_speed   <= spd_r;
        end
        default: begin
          out_x       <= sat32(ProdW'(ax_r));
          out_y       <= sat32(ProdW'(ay_r));
          out_heading <= pose_heading_r;
          out_speed   <= pose_speed_r;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/vpt_checker.sv]
// Port-level assertions for the vehicle pose tracker and their bind.
`timescale 1ns / 1ps
`default_nettype none
module vpt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_x,
  input wire logic [31:0] out_heading
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input ready right after a word was accepted.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("Result appeared in the cycle after acceptance.");

  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("Block still busy when a new result was posted.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_heading)))
    else $error("Stalled result word changed or dropped.");
endmodule

bind vehicle_pose_tracker vpt_checker u_vpt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_x       (out_x),
  .out_heading (out_heading)
);
`default_nettype wire
